>>> rtl/tq_pkg.sv
// Shared types and constants of the timer queue.
`default_nettype none
package tq_pkg;

    localparam logic [2:0] OP_START_ONCE     = 3'd0;
    localparam logic [2:0] OP_START_PERIODIC = 3'd1;
    localparam logic [2:0] OP_CANCEL         = 3'd2;
    localparam logic [2:0] OP_TICK           = 3'd3;
    localparam logic [2:0] OP_QUERY          = 3'd4;

    localparam logic [2:0] KIND_STARTED = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_FIRED   = 3'd2;
    localparam logic [2:0] KIND_QUERY   = 3'd3;
    localparam logic [2:0] KIND_CANCEL  = 3'd4;

    localparam int MAX_RESULTS = 16;
    localparam int FIRE_AW     = $clog2(MAX_RESULTS);
    localparam int TIME_W      = 48;
    localparam int ID_W        = 32;
    localparam int TO_W        = 49;
    localparam int PEND_W      = 7;
    localparam int REC_W       = ID_W + TIME_W + ID_W;

    typedef struct packed {
        logic       capture;
        logic       start_write;
        logic       scan_start;
        logic       scan_cancel;
        logic       clear_done;
        logic       tick_now;
        logic       tick_apply;
        logic       cancel_apply;
        logic       load_result;
        logic [2:0] res_kind;
        logic       emit_init;
        logic       emit_load;
    } tq_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       table_full;
        logic       scan_done;
        logic       due;
        logic       fire_full;
        logic       fire_empty;
        logic       emit_last;
        logic       out_busy;
    } tq_status_t;

endpackage
`default_nettype wire

>>> rtl/tq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/tq_datapath.sv
// Timer table storage, slot scan, clock and result register.
`default_nettype none
module tq_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire tq_pkg::tq_cmd_t     cmd,
    output tq_pkg::tq_status_t       status,
    input  wire logic [2:0]          in_op,
    input  wire logic [31:0]         in_amount,
    input  wire logic [31:0]         in_target,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [87:0]              m_tdata,
    output logic [2:0]               m_tuser,
    output logic                     m_tlast
);
    localparam int IW = $clog2(CAPACITY);
    localparam int NW = tq_pkg::FIRE_AW + 1;

    logic [2:0]                  op_reg;
    logic [31:0]                 amount_reg;
    logic [31:0]                 target_reg;
    logic [tq_pkg::TIME_W-1:0]   now_reg;
    logic [31:0]                 next_id_reg;
    logic [31:0]                 issued_id_reg;
    logic [CAPACITY-1:0]         used_reg;
    logic [CAPACITY-1:0]         cancelled_reg;
    logic [CAPACITY-1:0]         done_reg;

    logic [IW:0]                 scan_idx_reg;
    logic                        scan_run_reg;
    logic                        pipe_v_reg;
    logic [IW-1:0]               pipe_idx_reg;
    logic                        mode_cancel_reg;
    logic                        best_v_reg;
    logic [IW-1:0]               best_idx_reg;
    logic [31:0]                 best_ident_reg;
    logic [tq_pkg::TIME_W-1:0]   best_exp_reg;
    logic [31:0]                 best_per_reg;

    logic [NW-1:0]               nf_reg;
    logic [NW-1:0]               emit_k_reg;

    logic                        out_v_reg;
    logic [2:0]                  out_kind_reg;
    logic [31:0]                 out_id_reg;
    logic [tq_pkg::TO_W-1:0]     out_to_reg;
    logic [tq_pkg::PEND_W-1:0]   out_pend_reg;
    logic                        out_last_reg;

    logic                        issue;
    logic [tq_pkg::REC_W-1:0]    rec_rdata;
    logic [31:0]                 rec_ident;
    logic [tq_pkg::TIME_W-1:0]   rec_exp;
    logic [31:0]                 rec_per;
    logic                        elig;
    logic                        take;
    logic [IW-1:0]               free_idx;
    logic [31:0]                 add_b;
    logic [tq_pkg::TIME_W:0]     add_sum;
    logic [tq_pkg::TIME_W-1:0]   sat_sum;
    logic                        rec_we;
    logic [IW-1:0]               rec_waddr;
    logic [tq_pkg::REC_W-1:0]    rec_wdata;
    logic                        fire_we;
    logic [31:0]                 fire_rdata;
    logic [tq_pkg::PEND_W-1:0]   pend_count;
    logic [tq_pkg::TO_W-1:0]     query_to;
    logic                        slot_fires;

    assign issue = scan_run_reg && (scan_idx_reg != (IW+1)'(CAPACITY));
    assign rec_ident = rec_rdata[31:0];
    assign rec_exp   = rec_rdata[tq_pkg::TIME_W+31:32];
    assign rec_per   = rec_rdata[tq_pkg::REC_W-1:tq_pkg::TIME_W+32];

    always_comb begin
        if (mode_cancel_reg) begin
            elig = used_reg[pipe_idx_reg] && (rec_ident == target_reg);
            take = pipe_v_reg && elig && !best_v_reg;
        end else begin
            elig = used_reg[pipe_idx_reg] && !done_reg[pipe_idx_reg];
            take = pipe_v_reg && elig && (!best_v_reg || (rec_exp < best_exp_reg));
        end
    end

    always_comb begin
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        pend_count = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            pend_count = pend_count + tq_pkg::PEND_W'(used_reg[i]);
        end
    end

    assign add_b   = cmd.tick_apply ? best_per_reg : amount_reg;
    assign add_sum = {1'b0, now_reg} + {{(tq_pkg::TIME_W-31){1'b0}}, add_b};
    assign sat_sum = add_sum[tq_pkg::TIME_W] ? {tq_pkg::TIME_W{1'b1}}
                                             : add_sum[tq_pkg::TIME_W-1:0];

    assign slot_fires = !cancelled_reg[best_idx_reg];
    assign rec_we = cmd.start_write
                 || (cmd.tick_apply && slot_fires && (best_per_reg != '0));
    assign rec_waddr = cmd.start_write ? free_idx : best_idx_reg;
    always_comb begin
        if (cmd.start_write) begin
            rec_wdata = {(op_reg == tq_pkg::OP_START_PERIODIC) ? amount_reg : 32'd0,
                         sat_sum, next_id_reg};
        end else begin
            rec_wdata = {best_per_reg, sat_sum, best_ident_reg};
        end
    end
    assign fire_we = cmd.tick_apply && slot_fires;

    always_comb begin
        if (!best_v_reg) begin
            query_to = {tq_pkg::TO_W{1'b1}};
        end else if (cancelled_reg[best_idx_reg] || (best_exp_reg <= now_reg)) begin
            query_to = '0;
        end else begin
            query_to = {1'b0, best_exp_reg - now_reg};
        end
    end

    tq_ram #(.WIDTH(tq_pkg::REC_W), .DEPTH(CAPACITY)) u_slot_ram (
        .aclk  (aclk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .raddr (scan_idx_reg[IW-1:0]),
        .rdata (rec_rdata)
    );

    tq_ram #(.WIDTH(32), .DEPTH(tq_pkg::MAX_RESULTS)) u_fire_ram (
        .aclk  (aclk),
        .we    (fire_we),
        .waddr (nf_reg[tq_pkg::FIRE_AW-1:0]),
        .wdata (best_ident_reg),
        .raddr (emit_k_reg[tq_pkg::FIRE_AW-1:0]),
        .rdata (fire_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= in_op;
            amount_reg <= in_amount;
            target_reg <= in_target;
        end
        if (cmd.scan_start) begin
            mode_cancel_reg <= cmd.scan_cancel;
        end
        if (take) begin
            best_idx_reg   <= pipe_idx_reg;
            best_ident_reg <= rec_ident;
            best_exp_reg   <= rec_exp;
            best_per_reg   <= rec_per;
        end
        pipe_idx_reg <= scan_idx_reg[IW-1:0];
        if (cmd.start_write) begin
            issued_id_reg <= next_id_reg;
        end
        if (cmd.load_result) begin
            out_kind_reg <= cmd.res_kind;
            out_id_reg   <= (cmd.res_kind == tq_pkg::KIND_STARTED) ? issued_id_reg : 32'd0;
            out_to_reg   <= (cmd.res_kind == tq_pkg::KIND_QUERY) ? query_to : '0;
            out_pend_reg <= pend_count;
            out_last_reg <= 1'b1;
        end else if (cmd.emit_load) begin
            out_kind_reg <= tq_pkg::KIND_FIRED;
            out_id_reg   <= fire_rdata;
            out_to_reg   <= '0;
            out_pend_reg <= pend_count;
            out_last_reg <= status.emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg       <= '0;
            next_id_reg   <= 32'd1;
            used_reg      <= '0;
            cancelled_reg <= '0;
            done_reg      <= '0;
            scan_idx_reg  <= '0;
            scan_run_reg  <= 1'b0;
            pipe_v_reg    <= 1'b0;
            best_v_reg    <= 1'b0;
            nf_reg        <= '0;
            emit_k_reg    <= '0;
            out_v_reg     <= 1'b0;
        end else begin
            if (cmd.scan_start) begin
                scan_idx_reg <= '0;
                scan_run_reg <= 1'b1;
                pipe_v_reg   <= 1'b0;
                best_v_reg   <= 1'b0;
            end else begin
                if (issue) begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end else begin
                    scan_run_reg <= 1'b0;
                end
                pipe_v_reg <= issue;
                if (take) begin
                    best_v_reg <= 1'b1;
                end
            end
            if (cmd.clear_done) begin
                done_reg <= '0;
            end
            if (cmd.tick_now) begin
                now_reg <= sat_sum;
                nf_reg  <= '0;
            end
            if (cmd.start_write) begin
                used_reg[free_idx]      <= 1'b1;
                cancelled_reg[free_idx] <= 1'b0;
                next_id_reg             <= next_id_reg + 32'd1;
            end
            if (cmd.cancel_apply && best_v_reg) begin
                cancelled_reg[best_idx_reg] <= 1'b1;
            end
            if (cmd.tick_apply) begin
                done_reg[best_idx_reg] <= 1'b1;
                if (!slot_fires) begin
                    used_reg[best_idx_reg]      <= 1'b0;
                    cancelled_reg[best_idx_reg] <= 1'b0;
                end else begin
                    nf_reg <= nf_reg + 1'b1;
                    if (best_per_reg == '0) begin
                        used_reg[best_idx_reg] <= 1'b0;
                    end
                end
            end
            if (cmd.emit_init) begin
                emit_k_reg <= '0;
            end else if (cmd.emit_load) begin
                emit_k_reg <= emit_k_reg + 1'b1;
            end
            if (cmd.load_result || cmd.emit_load) begin
                out_v_reg <= 1'b1;
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    assign status.op         = op_reg;
    assign status.table_full = &used_reg;
    assign status.scan_done  = !scan_run_reg && !pipe_v_reg;
    assign status.due        = best_v_reg && (best_exp_reg <= now_reg);
    assign status.fire_full  = nf_reg == NW'(tq_pkg::MAX_RESULTS);
    assign status.fire_empty = nf_reg == '0;
    assign status.emit_last  = (emit_k_reg + 1'b1) == nf_reg;
    assign status.out_busy   = out_v_reg;

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_pend_reg, out_to_reg, out_id_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
endmodule
`default_nettype wire

>>> rtl/tq_ctrl.sv
// Sequencer for the timer queue operations.
`default_nettype none
module tq_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire tq_pkg::tq_status_t  status,
    output tq_pkg::tq_cmd_t          cmd
);
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DECODE    = 4'd1;
    localparam logic [3:0] ST_START     = 4'd2;
    localparam logic [3:0] ST_SCAN_C    = 4'd3;
    localparam logic [3:0] ST_SCAN_Q    = 4'd4;
    localparam logic [3:0] ST_TICK_LOOP = 4'd5;
    localparam logic [3:0] ST_TICK_SCAN = 4'd6;
    localparam logic [3:0] ST_TICK_EV   = 4'd7;
    localparam logic [3:0] ST_EMIT      = 4'd8;
    localparam logic [3:0] ST_EMIT_RD   = 4'd9;
    localparam logic [3:0] ST_EMIT_LD   = 4'd10;
    localparam logic [3:0] ST_RESULT    = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [2:0] kind_reg, kind_next;

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.res_kind = kind_reg;
        s_tready   = state_reg == ST_IDLE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (status.op) inside
                    tq_pkg::OP_START_ONCE, tq_pkg::OP_START_PERIODIC: begin
                        state_next = ST_START;
                    end
                    tq_pkg::OP_CANCEL: begin
                        cmd.scan_start  = 1'b1;
                        cmd.scan_cancel = 1'b1;
                        state_next      = ST_SCAN_C;
                    end
                    tq_pkg::OP_TICK: begin
                        cmd.tick_now   = 1'b1;
                        cmd.clear_done = 1'b1;
                        state_next     = ST_TICK_LOOP;
                    end
                    tq_pkg::OP_QUERY: begin
                        cmd.clear_done = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN_Q;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_START: begin
                if (status.table_full) begin
                    kind_next = tq_pkg::KIND_FULL;
                end else begin
                    cmd.start_write = 1'b1;
                    kind_next       = tq_pkg::KIND_STARTED;
                end
                state_next = ST_RESULT;
            end
            ST_SCAN_C: begin
                if (status.scan_done) begin
                    cmd.cancel_apply = 1'b1;
                    kind_next        = tq_pkg::KIND_CANCEL;
                    state_next       = ST_RESULT;
                end
            end
            ST_SCAN_Q: begin
                if (status.scan_done) begin
                    kind_next  = tq_pkg::KIND_QUERY;
                    state_next = ST_RESULT;
                end
            end
            ST_TICK_LOOP: begin
                if (status.fire_full) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_TICK_SCAN;
                end
            end
            ST_TICK_SCAN: begin
                if (status.scan_done) begin
                    state_next = ST_TICK_EV;
                end
            end
            ST_TICK_EV: begin
                if (status.due) begin
                    cmd.tick_apply = 1'b1;
                    state_next     = ST_TICK_LOOP;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                cmd.emit_init = 1'b1;
                state_next    = status.fire_empty ? ST_IDLE : ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (!status.out_busy) begin
                    cmd.emit_load = 1'b1;
                    state_next    = status.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_RESULT: begin
                if (!status.out_busy) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= tq_pkg::KIND_STARTED;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end
endmodule
`default_nettype wire

>>> rtl/timer_queue.sv
// Timer queue: table of software timers driven by tick, start, cancel and query items.
// Input items arrive on s_tvalid/s_tready; s_tuser carries the operation, s_tdata the
// delay or elapsed time and the identifier to cancel. Results leave on m_tvalid/m_tready
// with the result kind on m_tuser and m_tlast on the final result of an item.
// One item is worked on at a time; s_tready is high only while the sequencer is idle.
// Cancel and query: one pass over the slot memory, one slot read per cycle from the
// single read port. Tick: one pass for every entry it fires or drops, plus one final
// pass unless the fired-identifier buffer fills, then the fired results are read back
// in turn from that buffer. A tick with nothing due gives no result.
// Results sit in an output register; while the receiver stalls, the sequencer holds
// before loading the next result, and a new item can be taken once the last result
// of the previous one is loaded. Reset clears the clock and all slots and sets the
// identifier counter to 1; no clearing pass is needed.
`default_nettype none
module timer_queue #(
    parameter int CAPACITY = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // amount, target_id
    input  wire logic [2:0]  s_tuser,  // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,  // ident, next_timeout, pending
    output logic [2:0]       m_tuser,  // kind
    output logic             m_tlast
);
    tq_pkg::tq_cmd_t    cmd;
    tq_pkg::tq_status_t status;

    tq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tq_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_op     (s_tuser),
        .in_amount (s_tdata[31:0]),
        .in_target (s_tdata[63:32]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );
endmodule
`default_nettype wire

>>> dv/timer_queue_checker.sv
// Checker for the timer queue: tracks the timer table and compares every result.
`default_nettype none
module timer_queue_checker
    import tq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic [2:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [87:0] m_tdata,
    input  wire logic [2:0]  m_tuser,
    input  wire logic        m_tlast,
    output int               errors,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [2:0]        kind;
        logic [ID_W-1:0]   ident_out;
        logic [TO_W-1:0]   next_timeout;
        logic [PEND_W-1:0] pending;
        logic              last;
    } timer_result_t;

    timer_result_t results_due[$];

    logic [TIME_W-1:0] now_ms;
    logic [ID_W-1:0]   next_ident;
    logic              used [CAPACITY];
    logic              cancelled [CAPACITY];
    logic [ID_W-1:0]   ident [CAPACITY];
    logic [TIME_W-1:0] expiry [CAPACITY];
    logic [ID_W-1:0]   period [CAPACITY];

    function automatic logic [TIME_W-1:0] clamp_add(logic [TIME_W-1:0] t, logic [ID_W-1:0] d);
        logic [TIME_W:0] s;
        s = {1'b0, t} + d;
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function automatic logic [PEND_W-1:0] held();
        int n;
        n = 0;
        for (int i = 0; i < CAPACITY; i++) if (used[i]) n++;
        return PEND_W'(n);
    endfunction

    function automatic int soonest(logic skip [CAPACITY]);
        int best;
        best = -1;
        for (int i = 0; i < CAPACITY; i++)
            if (used[i] && !skip[i] && (best < 0 || expiry[i] < expiry[best])) best = i;
        return best;
    endfunction

    task automatic push_result(logic [2:0] kind, logic [ID_W-1:0] id, logic [TO_W-1:0] to,
                               logic last);
        timer_result_t r;
        r = '{kind, id, to, held(), last};
        results_due.insert(results_due.size(), r);
    endtask

    task automatic predict_item(logic [2:0] op, logic [31:0] amount, logic [31:0] target);
        int slot;
        int nf;
        logic skip [CAPACITY];
        logic [ID_W-1:0] fired [MAX_RESULTS];
        logic [TO_W-1:0] to;
        slot = -1;
        nf = 0;
        for (int i = 0; i < CAPACITY; i++) skip[i] = 1'b0;
        case (op)
            OP_START_ONCE, OP_START_PERIODIC: begin
                for (int i = 0; i < CAPACITY; i++)
                    if (!used[i] && slot < 0) slot = i;
                if (slot < 0) begin
                    push_result(KIND_FULL, '0, '0, 1'b1);
                end else begin
                    used[slot] = 1'b1;
                    cancelled[slot] = 1'b0;
                    ident[slot] = next_ident;
                    expiry[slot] = clamp_add(now_ms, amount);
                    period[slot] = (op == OP_START_PERIODIC) ? amount : '0;
                    push_result(KIND_STARTED, next_ident, '0, 1'b1);
                    next_ident = next_ident + 1;
                end
            end
            OP_CANCEL: begin
                for (int i = 0; i < CAPACITY; i++)
                    if (slot < 0 && used[i] && ident[i] == target) slot = i;
                if (slot >= 0) cancelled[slot] = 1'b1;
                push_result(KIND_CANCEL, '0, '0, 1'b1);
            end
            OP_TICK: begin
                now_ms = clamp_add(now_ms, amount);
                while (nf < MAX_RESULTS) begin
                    slot = soonest(skip);
                    if (slot < 0 || expiry[slot] > now_ms) break;
                    skip[slot] = 1'b1;
                    if (cancelled[slot]) begin
                        used[slot] = 1'b0;
                        cancelled[slot] = 1'b0;
                    end else begin
                        fired[nf] = ident[slot];
                        nf++;
                        if (period[slot] != 0) expiry[slot] = clamp_add(now_ms, period[slot]);
                        else used[slot] = 1'b0;
                    end
                end
                for (int k = 0; k < nf; k++)
                    push_result(KIND_FIRED, fired[k], '0, k == nf - 1);
            end
            OP_QUERY: begin
                slot = soonest(skip);
                if (slot < 0) to = '1;
                else if (cancelled[slot] || expiry[slot] <= now_ms) to = '0;
                else to = TO_W'(expiry[slot] - now_ms);
                push_result(KIND_QUERY, '0, to, 1'b1);
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        timer_result_t got, want;
        if (!aresetn) begin
            now_ms = '0;
            next_ident = 1;
            for (int i = 0; i < CAPACITY; i++) begin
                used[i] = 1'b0;
                cancelled[i] = 1'b0;
            end
            results_due.delete();
            errors = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[31:0], m_tdata[80:32], m_tdata[87:81], m_tlast};
                if (results_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, got);
                end else begin
                    want = results_due.pop_front();
                    if (got.kind != want.kind || got.ident_out != want.ident_out
                        || got.next_timeout != want.next_timeout
                        || got.pending != want.pending || got.last != want.last) begin
                        errors++;
                        $display("%0t: expected kind %0d id %h to %h pend %0d last %b",
                                 $time, want.kind, want.ident_out, want.next_timeout,
                                 want.pending, want.last);
                        $display("%0t: actual   kind %0d id %h to %h pend %0d last %b",
                                 $time, got.kind, got.ident_out, got.next_timeout,
                                 got.pending, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata[31:0], s_tdata[63:32]);
        end
        outstanding = results_due.size();
    end
endmodule
`default_nettype wire

>>> dv/timer_queue_test.sv
// Testbench top for the timer queue: stimulus, flow control and verdict.
`default_nettype none
module timer_queue_test;
    import tq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          errors;
    int          outstanding;
    int          stall_mode;
    logic [31:0] recent_id;

    timer_queue #(.CAPACITY(16)) dut (.*);
    timer_queue_checker #(.CAPACITY(16)) scoreboard (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #80ms;
        $display("timer_queue_test: FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready && m_tuser == KIND_STARTED) recent_id <= m_tdata[31:0];
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    end

    task automatic send_item(logic [2:0] op, logic [31:0] amount, logic [31:0] target);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {target, amount};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic rest(int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] pick_amount();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return $urandom();
            2: return 0;
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    initial begin
        int burst;
        int roll;
        logic [2:0] op;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b1;
        stall_mode = 0;
        recent_id = 1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(OP_QUERY, 0, 0);
        send_item(OP_START_ONCE, 0, 0);
        send_item(OP_START_PERIODIC, 0, 0);
        send_item(OP_START_PERIODIC, 5, 0);
        send_item(OP_START_ONCE, 32'hFFFF_FFFF, 0);
        send_item(OP_CANCEL, 2, 0);
        send_item(OP_CANCEL, 0, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_TICK, 0, 0);
        send_item(OP_TICK, 5, 0);
        send_item(OP_QUERY, 0, 0);
        for (int i = 0; i < 14; i++) send_item(OP_START_ONCE, 3, 0);
        send_item(OP_START_PERIODIC, 1, 0);
        send_item(3'd5, 0, 0);
        send_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_TICK, 32'hFFFF_FFFF, 0);
        send_item(OP_TICK, 32'hFFFF_FFFF, 0);
        send_item(OP_QUERY, 0, 0);

        for (int n = 0; n < 320; n += burst) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
                roll = $urandom_range(0, 99);
                if (roll < 25) op = OP_START_ONCE;
                else if (roll < 40) op = OP_START_PERIODIC;
                else if (roll < 55) op = OP_CANCEL;
                else if (roll < 80) op = OP_TICK;
                else if (roll < 96) op = OP_QUERY;
                else op = 3'($urandom_range(5, 7));
                send_item(op, (op == OP_TICK && $urandom_range(0, 3) != 0)
                              ? 32'($urandom_range(0, 12)) : pick_amount(),
                          $urandom_range(0, 1) ? recent_id - $urandom_range(0, 4)
                                               : $urandom());
            end
            rest($urandom_range(0, 1) ? 0 : $urandom_range(1, 40));
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (errors == 0) begin
            $display("timer_queue_test: PASS");
        end else begin
            $display("timer_queue_test: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
